FILE: sv/orv_pkg.sv
// ---------------------------------------------------------------------------
// orv_pkg
// Shared types, constants and the arctangent table for the obstacle
// repulsion vector pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package orv_pkg;

  // Defaults for top-level parameters
  localparam int SENSOR_BITS_DEF  = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // Port widths
  localparam int SENS_W  = 16;
  localparam int HEAD_W  = 16;
  localparam int GAIN_W  = 24;
  localparam int ANGC_W  = 14;
  localparam int OUT_W   = 24;
  localparam int CIDX_W  = 3;
  localparam int CDAT_W  = 24;

  // Internal angle and CORDIC formats
  localparam int ANG_W     = 18;   // wide enough for heading + 2.5 * angle
  localparam int CORD_XW   = 32;   // Q.30 rotation datapath
  localparam int CORD_ZW   = 28;   // Q.24 residual angle
  localparam int CS_W      = 18;   // Q.16 cos / sin
  localparam int ZSHIFT    = 11;   // Q3.13 to Q.24
  localparam int XSHIFT    = 14;   // Q.30 to Q.16
  localparam int OSHIFT    = 16;   // Q.32 to Q8.16

  localparam int ANG_PI       = 25736;
  localparam int ANG_TWO_PI   = 51472;
  localparam int ANG_HALF_PI  = 12868;
  localparam int CORDIC_GAIN  = 652032874;
  localparam int ATAN_LEN     = 24;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_SENSOR_OFFSET     = 3'd0;
  localparam logic [CIDX_W-1:0] REG_SENSOR_FULL_SCALE = 3'd1;
  localparam logic [CIDX_W-1:0] REG_SIDE_GAIN         = 3'd2;
  localparam logic [CIDX_W-1:0] REG_FRONT_GAIN        = 3'd3;
  localparam logic [CIDX_W-1:0] REG_BASE_PUSH         = 3'd4;
  localparam logic [CIDX_W-1:0] REG_OVERTAKE_ANGLE    = 3'd5;

  // Reset values
  localparam logic [SENS_W-1:0] RST_SENSOR_OFFSET     = 16'd0;
  localparam logic [SENS_W-1:0] RST_SENSOR_FULL_SCALE = 16'd65535;
  localparam logic [GAIN_W-1:0] RST_SIDE_GAIN         = 24'd983040;
  localparam logic [GAIN_W-1:0] RST_FRONT_GAIN        = 24'd1474560;
  localparam logic [GAIN_W-1:0] RST_BASE_PUSH         = 24'd3277;
  localparam logic [ANGC_W-1:0] RST_OVERTAKE_ANGLE    = 14'd6434;

  typedef struct packed {
    logic [SENS_W-1:0] sensor_offset;
    logic [SENS_W-1:0] sensor_full_scale;
    logic [GAIN_W-1:0] side_gain;
    logic [GAIN_W-1:0] front_gain;
    logic [GAIN_W-1:0] base_push;
    logic [ANGC_W-1:0] overtake_angle;
  } cfg_t;

  // atan(2^-i) in Q.24
  function automatic logic [23:0] atan_q24(input int idx);
    logic [23:0] r;
    case (idx)
      0:  r = 24'd13176795;
      1:  r = 24'd7778716;
      2:  r = 24'd4110060;
      3:  r = 24'd2086331;
      4:  r = 24'd1047214;
      5:  r = 24'd524117;
      6:  r = 24'd262123;
      7:  r = 24'd131069;
      8:  r = 24'd65536;
      9:  r = 24'd32768;
      10: r = 24'd16384;
      11: r = 24'd8192;
      12: r = 24'd4096;
      13: r = 24'd2048;
      14: r = 24'd1024;
      15: r = 24'd512;
      16: r = 24'd256;
      17: r = 24'd128;
      18: r = 24'd64;
      19: r = 24'd32;
      20: r = 24'd16;
      21: r = 24'd8;
      22: r = 24'd4;
      23: r = 24'd2;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/orv_cfg.sv
// ---------------------------------------------------------------------------
// orv_cfg
// Configuration register file written through a valid/ready channel.
// ---------------------------------------------------------------------------
`default_nettype none

module orv_cfg import orv_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CDAT_W-1:0] cfg_data,
  output cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sensor_offset     <= RST_SENSOR_OFFSET;
      cfg.sensor_full_scale <= RST_SENSOR_FULL_SCALE;
      cfg.side_gain         <= RST_SIDE_GAIN;
      cfg.front_gain        <= RST_FRONT_GAIN;
      cfg.base_push         <= RST_BASE_PUSH;
      cfg.overtake_angle    <= RST_OVERTAKE_ANGLE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SENSOR_OFFSET:     cfg.sensor_offset     <= cfg_data[SENS_W-1:0];
        REG_SENSOR_FULL_SCALE: cfg.sensor_full_scale <= cfg_data[SENS_W-1:0];
        REG_SIDE_GAIN:         cfg.side_gain         <= cfg_data[GAIN_W-1:0];
        REG_FRONT_GAIN:        cfg.front_gain        <= cfg_data[GAIN_W-1:0];
        REG_BASE_PUSH:         cfg.base_push         <= cfg_data[GAIN_W-1:0];
        REG_OVERTAKE_ANGLE:    cfg.overtake_angle    <= cfg_data[ANGC_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/orv_cordic.sv
// ---------------------------------------------------------------------------
// orv_cordic
// Pipelined rotation-mode CORDIC: quadrant fold, one stage per iteration,
// then rounding to Q.16 cos and sin.
// ---------------------------------------------------------------------------
`default_nettype none

module orv_cordic import orv_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                    clk,
  input  wire logic [STEPS+1:0]        en,
  input  wire logic signed [ANG_W-1:0] angle,
  output logic signed [CS_W-1:0]       cos_q,
  output logic signed [CS_W-1:0]       sin_q
);

  localparam logic signed [ANG_W-1:0] A_PI   = ANG_W'(ANG_PI);
  localparam logic signed [ANG_W-1:0] A_2PI  = ANG_W'(ANG_TWO_PI);
  localparam logic signed [ANG_W-1:0] A_HPI  = ANG_W'(ANG_HALF_PI);
  localparam logic signed [CORD_XW:0] X_RND  = (CORD_XW+1)'(2 ** (XSHIFT - 1));

  logic signed [ANG_W-1:0]   a_wrap, a_fold;
  logic                      fold;
  logic signed [CORD_ZW-1:0] z_in;

  logic signed [CORD_XW-1:0] xs [STEPS+1];
  logic signed [CORD_XW-1:0] ys [STEPS+1];
  logic signed [CORD_ZW-1:0] zs [STEPS+1];
  logic                      negs [STEPS+1];

  logic signed [CORD_XW:0]   x_rnd, y_rnd;
  logic signed [CS_W-1:0]    x_q, y_q;

  // Bring the angle into [-pi/2, pi/2], remembering a half-turn fold
  always_comb begin
    if (angle > A_PI) begin
      a_wrap = angle - A_2PI;
    end else if (angle < -A_PI) begin
      a_wrap = angle + A_2PI;
    end else begin
      a_wrap = angle;
    end
    if (a_wrap > A_HPI) begin
      a_fold = a_wrap - A_PI;
      fold   = 1'b1;
    end else if (a_wrap < -A_HPI) begin
      a_fold = a_wrap + A_PI;
      fold   = 1'b1;
    end else begin
      a_fold = a_wrap;
      fold   = 1'b0;
    end
    z_in = CORD_ZW'(a_fold) <<< ZSHIFT;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xs[0]   <= CORD_XW'(CORDIC_GAIN);
      ys[0]   <= '0;
      zs[0]   <= z_in;
      negs[0] <= fold;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    localparam logic signed [CORD_ZW-1:0] AT = CORD_ZW'(atan_q24(i));
    always_ff @(posedge clk) begin
      if (en[i+1]) begin
        if (!zs[i][CORD_ZW-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - AT;
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + AT;
        end
        negs[i+1] <= negs[i];
      end
    end
  end

  // Round half up to Q.16
  always_comb begin
    x_rnd = (CORD_XW+1)'(xs[STEPS]) + X_RND;
    y_rnd = (CORD_XW+1)'(ys[STEPS]) + X_RND;
    x_q   = x_rnd[XSHIFT+CS_W-1:XSHIFT];
    y_q   = y_rnd[XSHIFT+CS_W-1:XSHIFT];
  end

  always_ff @(posedge clk) begin
    if (en[STEPS+1]) begin
      cos_q <= negs[STEPS] ? -x_q : x_q;
      sin_q <= negs[STEPS] ? -y_q : y_q;
    end
  end

endmodule

`default_nettype wire

FILE: sv/orv_div.sv
// ---------------------------------------------------------------------------
// orv_div
// Pipelined restoring divider, one quotient bit per stage. Magnitude in,
// magnitude out; the sign travels alongside.
// ---------------------------------------------------------------------------
`default_nettype none

module orv_div import orv_pkg::*; #(
  parameter int SB = SENSOR_BITS_DEF,
  parameter int NB = GAIN_W + SENSOR_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic [NB:0]   en,
  input  wire logic [NB-1:0] num,
  input  wire logic          num_neg,
  input  wire logic [SB-1:0] den,
  output logic [NB-1:0]      quo,
  output logic               quo_neg
);

  logic [NB-1:0] nq  [NB+1];
  logic [SB-1:0] rem [NB+1];
  logic          sg  [NB+1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      nq[0]  <= num;
      rem[0] <= '0;
      sg[0]  <= num_neg;
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_step
    logic [SB:0] t, t_sub;
    logic        ge;
    assign t     = {rem[j], nq[j][NB-1]};
    assign t_sub = t - {1'b0, den};
    assign ge    = (t >= {1'b0, den});
    always_ff @(posedge clk) begin
      if (en[j+1]) begin
        nq[j+1]  <= {nq[j][NB-2:0], ge};
        rem[j+1] <= ge ? t_sub[SB-1:0] : t[SB-1:0];
        sg[j+1]  <= sg[j];
      end
    end
  end

  assign quo     = nq[NB];
  assign quo_neg = sg[NB];

endmodule

`default_nettype wire

FILE: sv/obstacle_repulsion_vector.sv
// ---------------------------------------------------------------------------
// obstacle_repulsion_vector
// Potential-field steering vector from four proximity beams and a heading.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------
//   in      | input     | in_valid / in_ready     | readings, heading
//   out     | output    | out_valid / out_ready   | force_x, force_y, saturated
//   cfg     | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One reading set per cycle unless a stalled output has filled the pipeline;
// most of the pipeline depth lies in the bit-per-stage dividers.
// Each stage holds a valid bit; a stage advances when it is empty or the
// stage after it advances, so bubbles collapse and a stalled output still
// lets new sets enter until the pipeline is full.
// Synchronous reset clears valid bits and loads register defaults.
// ---------------------------------------------------------------------------
`default_nettype none

module obstacle_repulsion_vector import orv_pkg::*; #(
  parameter int SENSOR_BITS  = SENSOR_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [SENS_W-1:0]        front_right,
  input  wire logic [SENS_W-1:0]        right_front,
  input  wire logic [SENS_W-1:0]        left_front,
  input  wire logic [SENS_W-1:0]        front_left,
  input  wire logic signed [HEAD_W-1:0] heading,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [OUT_W-1:0]       force_x,
  output logic signed [OUT_W-1:0]       force_y,
  output logic                          saturated,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CIDX_W-1:0]        cfg_index,
  input  wire logic [CDAT_W-1:0]        cfg_data
);

  localparam int SB    = SENSOR_BITS;
  localparam int NB    = GAIN_W + SB;
  localparam int MAG_W = NB + 1;
  localparam int PW    = MAG_W + CS_W;
  localparam int SW    = PW + 3;
  localparam int L     = NB + 5;
  localparam int DLY   = NB - CORDIC_STEPS;
  localparam int NBEAM = 5;

  localparam logic signed [SW-1:0] S_RND = SW'(2 ** (OSHIFT - 1));
  localparam logic signed [SW-1:0] O_MAX = SW'(2 ** (OUT_W - 1) - 1);
  localparam logic signed [SW-1:0] O_MIN = -SW'(2 ** (OUT_W - 1));

  cfg_t cfg;

  orv_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stage flow control
  logic [L-1:0] v, en;

  always_comb begin
    en[L-1] = ~v[L-1] | out_ready;
    for (int k = L - 2; k >= 0; k--) begin
      en[k] = ~v[k] | en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < L; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[L-1];

  // Readings, offset and full scale in their low SENSOR_BITS bits
  logic [SB-1:0]          fr, rf, lf, fl, off, fs;
  logic signed [SB:0]     den_off;
  logic                   off_ok, fs_ok;

  assign fr      = front_right[SB-1:0];
  assign rf      = right_front[SB-1:0];
  assign lf      = left_front[SB-1:0];
  assign fl      = front_left[SB-1:0];
  assign off     = cfg.sensor_offset[SB-1:0];
  assign fs      = cfg.sensor_full_scale[SB-1:0];
  assign den_off = $signed({1'b0, fs}) - $signed({1'b0, off});
  assign off_ok  = !den_off[SB] && (den_off != '0);
  assign fs_ok   = (fs != '0);

  // Divider beams: index 1..4 = front_right, right_front, left_front, front_left
  logic signed [SB:0]  diff [1:NBEAM-1];
  logic [GAIN_W-1:0]   gain [1:NBEAM-1];
  logic [SB-1:0]       dvs  [1:NBEAM-1];
  logic                dok  [1:NBEAM-1];

  always_comb begin
    diff[1] = $signed({1'b0, fr}) - $signed({1'b0, off});
    diff[2] = $signed({1'b0, rf}) - $signed({1'b0, off});
    diff[3] = $signed({1'b0, lf}) - $signed({1'b0, off});
    diff[4] = $signed({1'b0, fl}) - $signed({1'b0, fr});
    gain[1] = cfg.front_gain;
    gain[2] = cfg.side_gain;
    gain[3] = cfg.side_gain;
    gain[4] = cfg.front_gain;
    dvs[1]  = den_off[SB-1:0];
    dvs[2]  = den_off[SB-1:0];
    dvs[3]  = den_off[SB-1:0];
    dvs[4]  = fs;
    dok[1]  = off_ok;
    dok[2]  = off_ok;
    dok[3]  = off_ok;
    dok[4]  = fs_ok;
  end

  logic [NB-1:0]            quo     [1:NBEAM-1];
  logic                     quo_neg [1:NBEAM-1];
  logic signed [MAG_W-1:0]  mag     [NBEAM];

  for (genvar b = 1; b < NBEAM; b++) begin : g_div
    logic [SB:0]   dabs;
    logic [NB-1:0] num;
    assign dabs = diff[b][SB] ? -diff[b] : diff[b];
    assign num  = NB'(gain[b]) * NB'(dabs[SB-1:0]);

    orv_div #(.SB(SB), .NB(NB)) u_div (
      .clk     (clk),
      .en      (en[NB:0]),
      .num     (num),
      .num_neg (diff[b][SB]),
      .den     (dvs[b]),
      .quo     (quo[b]),
      .quo_neg (quo_neg[b])
    );

    // Apply sign; drop the beam when its divisor is not positive
    always_ff @(posedge clk) begin
      if (en[NB+1]) begin
        if (!dok[b]) begin
          mag[b] <= '0;
        end else if (quo_neg[b]) begin
          mag[b] <= -$signed({1'b0, quo[b]});
        end else begin
          mag[b] <= $signed({1'b0, quo[b]});
        end
      end
    end
  end

  assign mag[0] = $signed(MAG_W'(cfg.base_push));

  // Beam angles: base, +2.5A, +A, -A, -2.5A around the heading
  logic [16:0]             a5;
  logic signed [ANG_W-1:0] a1, a25, head;
  logic signed [ANG_W-1:0] ang [NBEAM];

  always_comb begin
    a5     = 17'({cfg.overtake_angle, 2'b00}) + 17'(cfg.overtake_angle);
    a1     = $signed(ANG_W'(cfg.overtake_angle));
    a25    = $signed(ANG_W'(a5[16:1]));
    head   = ANG_W'(heading);
    ang[0] = head;
    ang[1] = head + a25;
    ang[2] = head + a1;
    ang[3] = head - a1;
    ang[4] = head - a25;
  end

  logic signed [CS_W-1:0] cs_c [NBEAM];
  logic signed [CS_W-1:0] cs_s [NBEAM];
  logic signed [PW-1:0]   px   [NBEAM];
  logic signed [PW-1:0]   py   [NBEAM];

  for (genvar b = 0; b < NBEAM; b++) begin : g_rot
    logic signed [CS_W-1:0] c_q, s_q;
    logic signed [CS_W-1:0] c_d [DLY];
    logic signed [CS_W-1:0] s_d [DLY];

    orv_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clk   (clk),
      .en    (en[CORDIC_STEPS+1:0]),
      .angle (ang[b]),
      .cos_q (c_q),
      .sin_q (s_q)
    );

    // Hold cos/sin until the matching magnitude leaves the divider
    always_ff @(posedge clk) begin
      if (en[CORDIC_STEPS+2]) begin
        c_d[0] <= c_q;
        s_d[0] <= s_q;
      end
      for (int j = 1; j < DLY; j++) begin
        if (en[CORDIC_STEPS+2+j]) begin
          c_d[j] <= c_d[j-1];
          s_d[j] <= s_d[j-1];
        end
      end
    end

    assign cs_c[b] = c_d[DLY-1];
    assign cs_s[b] = s_d[DLY-1];

    always_ff @(posedge clk) begin
      if (en[NB+2]) begin
        px[b] <= mag[b] * cs_c[b];
        py[b] <= mag[b] * cs_s[b];
      end
    end
  end

  // Partial sums, then final sum, round and clip
  logic signed [SW-1:0] sx_a, sx_b, sx_c, sy_a, sy_b, sy_c;
  logic signed [SW-1:0] sx, sy, rx, ry;
  logic                 hx, lx, hy, ly;

  always_ff @(posedge clk) begin
    if (en[NB+3]) begin
      sx_a <= SW'(px[0]) + SW'(px[1]);
      sx_b <= SW'(px[2]) + SW'(px[3]);
      sx_c <= SW'(px[4]);
      sy_a <= SW'(py[0]) + SW'(py[1]);
      sy_b <= SW'(py[2]) + SW'(py[3]);
      sy_c <= SW'(py[4]);
    end
  end

  always_comb begin
    sx = sx_a + sx_b + sx_c + S_RND;
    sy = sy_a + sy_b + sy_c + S_RND;
    rx = sx >>> OSHIFT;
    ry = sy >>> OSHIFT;
    hx = rx > O_MAX;
    lx = rx < O_MIN;
    hy = ry > O_MAX;
    ly = ry < O_MIN;
  end

  always_ff @(posedge clk) begin
    if (en[NB+4]) begin
      force_x   <= hx ? O_MAX[OUT_W-1:0] : (lx ? O_MIN[OUT_W-1:0] : rx[OUT_W-1:0]);
      force_y   <= hy ? O_MAX[OUT_W-1:0] : (ly ? O_MIN[OUT_W-1:0] : ry[OUT_W-1:0]);
      saturated <= hx | lx | hy | ly;
    end
  end

endmodule

`default_nettype wire

FILE: verif/orv_checker.sv
// ---------------------------------------------------------------------------
// orv_checker
// Watches the reading, result and register channels of the repulsion vector
// block, computes the expected steering vector for every accepted reading
// set, and compares each accepted result field by field in order.
// ---------------------------------------------------------------------------
module orv_checker import orv_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [SENS_W-1:0]        front_right,
  input  logic [SENS_W-1:0]        right_front,
  input  logic [SENS_W-1:0]        left_front,
  input  logic [SENS_W-1:0]        front_left,
  input  logic signed [HEAD_W-1:0] heading,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [OUT_W-1:0]  force_x,
  input  logic signed [OUT_W-1:0]  force_y,
  input  logic                     saturated,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CIDX_W-1:0]        cfg_index,
  input  logic [CDAT_W-1:0]        cfg_data,
  output int                       errors,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [OUT_W-1:0] fx;
    logic signed [OUT_W-1:0] fy;
    logic                    sat;
  } force_t;

  localparam int SENSOR_BITS  = SENSOR_BITS_DEF;
  localparam int CORDIC_STEPS = CORDIC_STEPS_DEF;

  cfg_t   regs;
  force_t vectors_due[$];

  assign pending = vectors_due.size();

  function automatic longint atan_entry(int i);
    longint t[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                      262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                      1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
    return t[i];
  endfunction

  // cos and sin of a Q3.13 angle in Q.16
  function automatic void unit_vector(longint ang, output longint c,
                                      output longint s);
    bit     flip;
    longint x, y, z, nx;
    flip = 0;
    x = CORDIC_GAIN;
    y = 0;
    while (ang > ANG_PI) ang -= ANG_TWO_PI;
    while (ang < -ANG_PI) ang += ANG_TWO_PI;
    if (ang > ANG_HALF_PI) begin
      ang -= ANG_PI;
      flip = 1;
    end else if (ang < -ANG_HALF_PI) begin
      ang += ANG_PI;
      flip = 1;
    end
    z = ang * 2048;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= atan_entry(i);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += atan_entry(i);
      end
      x = nx;
    end
    x = (x + 8192) >>> 14;
    y = (y + 8192) >>> 14;
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint beam_length(longint gain, longint diff, longint den);
    if (den <= 0) return 0;
    return (gain * diff) / den;  // truncates toward zero
  endfunction

  function automatic logic signed [OUT_W-1:0] clip(longint v, ref bit sat);
    if (v > 8388607) begin
      sat = 1;
      return 24'sh7FFFFF;
    end
    if (v < -8388608) begin
      sat = 1;
      return -24'sh800000;
    end
    return v[OUT_W-1:0];
  endfunction

  function automatic force_t steering_vector(longint fr, longint rf, longint lf,
                                             longint fl, longint hd);
    longint mask, off, fs, den, a1, a25, sx, sy, c, s;
    longint mag[5], ang[5];
    bit     sat;
    force_t r;
    mask = (64'd1 << SENSOR_BITS) - 1;
    fr &= mask; rf &= mask; lf &= mask; fl &= mask;
    off = regs.sensor_offset & mask;
    fs  = regs.sensor_full_scale & mask;
    den = fs - off;
    a1  = regs.overtake_angle;
    a25 = (5 * a1) >> 1;
    mag[0] = regs.base_push;                              ang[0] = hd;
    mag[1] = beam_length(regs.front_gain, fr - off, den); ang[1] = hd + a25;
    mag[2] = beam_length(regs.side_gain, rf - off, den);  ang[2] = hd + a1;
    mag[3] = beam_length(regs.side_gain, lf - off, den);  ang[3] = hd - a1;
    mag[4] = beam_length(regs.front_gain, fl - fr, fs);   ang[4] = hd - a25;
    sx = 0;
    sy = 0;
    for (int b = 0; b < 5; b++) begin
      unit_vector(ang[b], c, s);
      sx += mag[b] * c;
      sy += mag[b] * s;
    end
    sat = 0;
    r.fx = clip((sx + 32768) >>> 16, sat);
    r.fy = clip((sy + 32768) >>> 16, sat);
    r.sat = sat;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    force_t want;
    if (rst) begin
      regs.sensor_offset     <= RST_SENSOR_OFFSET;
      regs.sensor_full_scale <= RST_SENSOR_FULL_SCALE;
      regs.side_gain         <= RST_SIDE_GAIN;
      regs.front_gain        <= RST_FRONT_GAIN;
      regs.base_push         <= RST_BASE_PUSH;
      regs.overtake_angle    <= RST_OVERTAKE_ANGLE;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SENSOR_OFFSET:     regs.sensor_offset     <= cfg_data[SENS_W-1:0];
          REG_SENSOR_FULL_SCALE: regs.sensor_full_scale <= cfg_data[SENS_W-1:0];
          REG_SIDE_GAIN:         regs.side_gain         <= cfg_data;
          REG_FRONT_GAIN:        regs.front_gain        <= cfg_data;
          REG_BASE_PUSH:         regs.base_push         <= cfg_data;
          REG_OVERTAKE_ANGLE:    regs.overtake_angle    <= cfg_data[ANGC_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        vectors_due.push_back(steering_vector(front_right, right_front, left_front,
                                              front_left, longint'(heading)));
      if (out_valid && out_ready) begin
        if (vectors_due.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = vectors_due.pop_front();
          if (force_x !== want.fx)
            report_mismatch($sformatf("force_x %0d, expected %0d", force_x, want.fx));
          if (force_y !== want.fy)
            report_mismatch($sformatf("force_y %0d, expected %0d", force_y, want.fy));
          if (saturated !== want.sat)
            report_mismatch($sformatf("saturated %0b, expected %0b", saturated,
                                      want.sat));
        end
      end
    end
  end
endmodule

FILE: verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives reading sets and register settings into the repulsion vector
// block with random idle bursts and a long output stall; the checker
// predicts and compares each result.
// ---------------------------------------------------------------------------
module testbench import orv_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 120;

  logic                     clk = 0;
  logic                     rst = 1;
  logic                     in_valid = 0;
  logic                     in_ready;
  logic [SENS_W-1:0]        front_right = 0, right_front = 0;
  logic [SENS_W-1:0]        left_front = 0, front_left = 0;
  logic signed [HEAD_W-1:0] heading = 0;
  logic                     out_valid;
  logic                     out_ready = 0;
  logic signed [OUT_W-1:0]  force_x, force_y;
  logic                     saturated;
  logic                     cfg_valid = 0;
  logic                     cfg_ready;
  logic [CIDX_W-1:0]        cfg_index = 0;
  logic [CDAT_W-1:0]        cfg_data = 0;
  int                       errors, pending;
  bit                       calm = 0;
  bit                       hold_output = 0;
  bit                       long_hold = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  obstacle_repulsion_vector u_dut (.*);
  orv_checker u_chk (.*);

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic send_readings(logic [SENS_W-1:0] fr, logic [SENS_W-1:0] rf,
                               logic [SENS_W-1:0] lf, logic [SENS_W-1:0] fl,
                               logic signed [HEAD_W-1:0] hd);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1;
    front_right <= fr;
    right_front <= rf;
    left_front  <= lf;
    front_left  <= fl;
    heading     <= hd;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle;
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_set(int n);
    logic signed [HEAD_W-1:0] hd;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: hd = HEAD_W'($urandom);
        default: hd = HEAD_W'($signed($urandom_range(0, 51472)) - 25736);
      endcase
      send_readings(SENS_W'($urandom), SENS_W'($urandom), SENS_W'($urandom),
                    SENS_W'($urandom), hd);
    end
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst || hold_output || long_hold) out_ready <= 0;
    else if (calm) out_ready <= 1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  initial begin
    int stall;
    forever begin
      @(posedge clk);
      if (!calm && !rst && $urandom_range(0, 40) == 0) begin
        stall = $urandom_range(1, 18);
        hold_output <= 1;
        repeat (stall) @(posedge clk);
        hold_output <= 0;
      end
    end
  end

  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: field extremes at reset settings
    send_readings(0, 0, 0, 0, 0);
    send_readings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sd25736);
    send_readings(16'hFFFF, 0, 16'hFFFF, 0, -16'sd25736);
    send_readings(0, 16'hFFFF, 0, 16'hFFFF, 16'sh7FFF);
    send_readings(16'h5555, 16'hAAAA, 16'h1234, 16'hFEDC, -16'sh8000);
    send_readings(100, 200, 300, 400, 16'sd12868);
    send_readings(100, 200, 300, 400, 16'sd12869);
    settle();

    // readings below offset, heavy gains for saturation
    write_reg(REG_SENSOR_OFFSET, 24'd40000);
    write_reg(REG_SENSOR_FULL_SCALE, 24'd50000);
    write_reg(REG_SIDE_GAIN, 24'hFFFFFF);
    write_reg(REG_FRONT_GAIN, 24'hFFFFFF);
    write_reg(REG_BASE_PUSH, 24'hFFFFFF);
    write_reg(REG_OVERTAKE_ANGLE, 24'd12868);
    send_readings(0, 0, 0, 0, 0);
    send_readings(16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 16'sd6000);
    send_readings(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, -16'sd20000);
    random_set(20);
    settle();

    // full scale not above offset; angle above half pi
    write_reg(REG_SENSOR_FULL_SCALE, 24'd30000);
    write_reg(REG_OVERTAKE_ANGLE, 24'h3FFF);
    send_readings(16'hFFFF, 5, 16'hFFFF, 0, 16'sd1000);
    random_set(15);
    settle();

    // zero full scale, zero gains and angle
    write_reg(REG_SENSOR_OFFSET, 24'd0);
    write_reg(REG_SENSOR_FULL_SCALE, 24'd0);
    write_reg(REG_SIDE_GAIN, 24'd0);
    write_reg(REG_FRONT_GAIN, 24'd0);
    write_reg(REG_BASE_PUSH, 24'd0);
    write_reg(REG_OVERTAKE_ANGLE, 24'd0);
    send_readings(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 16'sd100);
    random_set(15);
    settle();

    // defaults again, long output hold-off so the pipeline backs up
    write_reg(REG_SENSOR_FULL_SCALE, 24'd65535);
    write_reg(REG_SIDE_GAIN, RST_SIDE_GAIN);
    write_reg(REG_FRONT_GAIN, RST_FRONT_GAIN);
    write_reg(REG_BASE_PUSH, RST_BASE_PUSH);
    write_reg(REG_OVERTAKE_ANGLE, RST_OVERTAKE_ANGLE);
    fork
      begin
        @(posedge clk);
        long_hold <= 1;
        repeat (150) @(posedge clk);
        long_hold <= 0;
      end
      random_set(120);
    join
    settle();

    // random settings per phase
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_SENSOR_OFFSET, CDAT_W'($urandom_range(0, 20000)));
      write_reg(REG_SENSOR_FULL_SCALE, CDAT_W'($urandom_range(20001, 65535)));
      write_reg(REG_SIDE_GAIN, CDAT_W'($urandom_range(0, 24'hFFFFFF)));
      write_reg(REG_FRONT_GAIN, CDAT_W'($urandom_range(0, 4000000)));
      write_reg(REG_BASE_PUSH, CDAT_W'($urandom));
      write_reg(REG_OVERTAKE_ANGLE, CDAT_W'($urandom_range(0, 12868)));
      if (p == 5) calm = 1;
      random_set(120);
      settle();
    end

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
